// ===== sv/relay_pulse_motor_sequencer_defines.svh =====
// Assertion macros used by the relay pulse motor sequencer checker.
`ifndef RELAY_PULSE_MOTOR_SEQUENCER_DEFINES_SVH
`define RELAY_PULSE_MOTOR_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RPMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RPMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rpms_pkg.sv =====
// Package with types, codes and constants of the relay pulse motor sequencer.
`default_nettype none
package rpms_pkg;

  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int IN_W          = 8;
  localparam int OUT_W         = 40;
  localparam int RUN_OUT_W     = 32;
  localparam int COUNT_BITS_DEF = 16;
  localparam int RUN_BITS_DEF  = 32;
  localparam int BOTH_GAP_TICKS = 50;
  localparam int SETTLE_STEPS  = 3;
  localparam int Q_DEPTH       = 2;

  localparam logic [RUN_OUT_W-1:0] RUN_OUT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_START_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_PULSE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_GAP  = 2'd2;

  localparam logic [CFG_W-1:0] START_PULSE_RST = 16'd1000;
  localparam logic [CFG_W-1:0] STOP_PULSE_RST  = 16'd1000;
  localparam logic [CFG_W-1:0] SWITCH_GAP_RST  = 16'd500;

  localparam logic [2:0] ACT_TICK       = 3'd0;
  localparam logic [2:0] ACT_START      = 3'd1;
  localparam logic [2:0] ACT_START_NS   = 3'd2;
  localparam logic [2:0] ACT_STOP       = 3'd3;
  localparam logic [2:0] ACT_STOP_BOTH  = 3'd4;
  localparam logic [2:0] ACT_RAW_START  = 3'd5;
  localparam logic [2:0] ACT_RAW_STOP   = 3'd6;

  typedef enum logic [2:0] {
    K_TICK, K_START, K_START_NS, K_STOP, K_STOP_BOTH, K_RAW_START, K_RAW_STOP, K_INVALID
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_EXT  = 2'd1,
    MODE_RET  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    PH_NONE, PH_STOP_RUN, PH_GAP, PH_START, PH_STOP, PH_EXT_STOP, PH_BOTH_GAP, PH_RET_STOP
  } phase_t;

  typedef struct packed {
    kind_t kind;
    logic  dir;
    logic  pulse;
  } item_t;

endpackage
`default_nettype wire

// ===== sv/rpms_front.sv =====
// Front end: accepts input transactions and classifies the action code.
`default_nettype none
module rpms_front import rpms_pkg::*; (
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [IN_W-1:0] in_tdata,  // action[2:0], direction[3], with_pulse[4]
  input  wire logic            q_full,
  output logic                 q_push,
  output item_t                q_item
);

  logic [2:0] action;

  assign action    = in_tdata[2:0];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.dir   = in_tdata[3];
    q_item.pulse = in_tdata[4];
    case (action)
      ACT_TICK:      q_item.kind = K_TICK;
      ACT_START:     q_item.kind = K_START;
      ACT_START_NS:  q_item.kind = K_START_NS;
      ACT_STOP:      q_item.kind = K_STOP;
      ACT_STOP_BOTH: q_item.kind = K_STOP_BOTH;
      ACT_RAW_START: q_item.kind = K_RAW_START;
      ACT_RAW_STOP:  q_item.kind = K_RAW_STOP;
      default:       q_item.kind = K_INVALID;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/rpms_queue.sv =====
// Short queue of classified items between the front and the back end.
`default_nettype none
module rpms_queue import rpms_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  item_t      push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output item_t      head_item
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  item_t            mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/rpms_back.sv =====
// Back end: runs the pulse sequencer on each item and holds the result register.
`default_nettype none
module rpms_back import rpms_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int RUN_BITS   = RUN_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 q_valid,
  input  item_t                     q_item,
  output logic                      q_pop,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [OUT_W-1:0]          out_tdata
);

  localparam int CW = CFG_W + COUNT_BITS;
  localparam int RW = RUN_BITS + RUN_OUT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [RUN_BITS-1:0]   RUN_MAX = '1;

  logic [CFG_W-1:0]      start_len_r, stop_len_r, gap_len_r;
  mode_t                 mode_r, mode_nxt, fmode_r, fmode_nxt;
  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  tdir_r, tdir_nxt;
  logic [RUN_BITS-1:0]   run_r, run_nxt;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r, out_data_nxt;

  logic [COUNT_BITS-1:0] start_sat, stop_sat, gap_sat, both_gap;
  logic                  rej, ext_on, ret_on;
  logic [RW-1:0]         run_wide;
  logic [RUN_OUT_W-1:0]  run_out;

  // Long register values clamp to the countdown range.
  function automatic logic [COUNT_BITS-1:0] sat_len(input logic [CFG_W-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w > CW'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return w[COUNT_BITS-1:0];
  endfunction

  assign start_sat = sat_len(start_len_r);
  assign stop_sat  = sat_len(stop_len_r);
  assign gap_sat   = sat_len(gap_len_r);
  assign both_gap  = COUNT_BITS'(BOTH_GAP_TICKS);

  assign q_pop      = q_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    mode_nxt  = mode_r;
    fmode_nxt = fmode_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    tdir_nxt  = tdir_r;
    run_nxt   = run_r;
    rej       = 1'b0;

    case (q_item.kind)
      K_TICK: begin
        if (mode_nxt != MODE_IDLE && run_nxt != RUN_MAX) begin
          run_nxt = run_nxt + 1'b1;
        end
        if (phase_nxt != PH_NONE && cnt_nxt != '0) begin
          cnt_nxt = cnt_nxt - 1'b1;
        end
      end
      K_INVALID: begin
        rej = 1'b1;
      end
      default: begin
        if (phase_r != PH_NONE) begin
          rej = 1'b1;
        end else begin
          tdir_nxt = q_item.dir;
          case (q_item.kind)
            K_START: begin
              fmode_nxt = q_item.dir ? MODE_RET : MODE_EXT;
              if (mode_r != MODE_IDLE) begin
                phase_nxt = PH_STOP_RUN;
                cnt_nxt   = stop_sat;
              end else begin
                phase_nxt = PH_START;
                cnt_nxt   = start_sat;
              end
            end
            K_START_NS, K_RAW_START: begin
              fmode_nxt = q_item.dir ? MODE_RET : MODE_EXT;
              phase_nxt = PH_START;
              cnt_nxt   = start_sat;
            end
            K_STOP: begin
              fmode_nxt = MODE_IDLE;
              if (q_item.pulse) begin
                phase_nxt = PH_STOP;
                cnt_nxt   = stop_sat;
              end else begin
                mode_nxt = MODE_IDLE;
              end
            end
            K_STOP_BOTH: begin
              phase_nxt = PH_EXT_STOP;
              cnt_nxt   = stop_sat;
            end
            K_RAW_STOP: begin
              fmode_nxt = mode_r;
              phase_nxt = PH_STOP;
              cnt_nxt   = stop_sat;
            end
            default: ;
          endcase
        end
      end
    endcase

    // Phases of zero length finish within the same item; at most three chain up
    // (stop pulse, switch gap, start pulse).
    for (int i = 0; i < SETTLE_STEPS; i++) begin
      if (phase_nxt != PH_NONE && cnt_nxt == '0) begin
        case (phase_nxt)
          PH_STOP_RUN: begin
            mode_nxt  = MODE_IDLE;
            phase_nxt = PH_GAP;
            cnt_nxt   = gap_sat;
          end
          PH_GAP: begin
            phase_nxt = PH_START;
            cnt_nxt   = start_sat;
          end
          PH_START: begin
            mode_nxt  = fmode_nxt;
            run_nxt   = '0;
            phase_nxt = PH_NONE;
            cnt_nxt   = '0;
          end
          PH_STOP: begin
            mode_nxt  = fmode_nxt;
            phase_nxt = PH_NONE;
            cnt_nxt   = '0;
          end
          PH_EXT_STOP: begin
            phase_nxt = PH_BOTH_GAP;
            cnt_nxt   = both_gap;
          end
          PH_BOTH_GAP: begin
            phase_nxt = PH_RET_STOP;
            cnt_nxt   = stop_sat;
          end
          PH_RET_STOP: begin
            mode_nxt  = MODE_IDLE;
            phase_nxt = PH_NONE;
            cnt_nxt   = '0;
          end
          default: begin
            phase_nxt = PH_NONE;
            cnt_nxt   = '0;
          end
        endcase
      end
    end

    ext_on = 1'b0;
    ret_on = 1'b0;
    case (phase_nxt)
      PH_STOP_RUN: begin
        if (mode_nxt == MODE_RET) begin
          ret_on = 1'b1;
        end else begin
          ext_on = 1'b1;
        end
      end
      PH_START, PH_STOP: begin
        if (tdir_nxt) begin
          ret_on = 1'b1;
        end else begin
          ext_on = 1'b1;
        end
      end
      PH_EXT_STOP: ext_on = 1'b1;
      PH_RET_STOP: ret_on = 1'b1;
      default: ;
    endcase

    run_wide = RW'(run_nxt);
    if (mode_nxt == MODE_IDLE) begin
      run_out = '0;
    end else if (run_wide > RW'(RUN_OUT_MAX)) begin
      run_out = RUN_OUT_MAX;
    end else begin
      run_out = run_wide[RUN_OUT_W-1:0];
    end

    out_data_nxt = OUT_W'({run_out, rej, (phase_nxt != PH_NONE), mode_nxt, ret_on, ext_on});
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_len_r <= START_PULSE_RST;
      stop_len_r  <= STOP_PULSE_RST;
      gap_len_r   <= SWITCH_GAP_RST;
      mode_r      <= MODE_IDLE;
      fmode_r     <= MODE_IDLE;
      phase_r     <= PH_NONE;
      cnt_r       <= '0;
      tdir_r      <= 1'b0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_PULSE: start_len_r <= cfg_data;
          REG_STOP_PULSE:  stop_len_r  <= cfg_data;
          REG_SWITCH_GAP:  gap_len_r   <= cfg_data;
          default: ;
        endcase
      end
      if (q_pop) begin
        mode_r      <= mode_nxt;
        fmode_r     <= fmode_nxt;
        phase_r     <= phase_nxt;
        cnt_r       <= cnt_nxt;
        tdir_r      <= tdir_nxt;
        run_r       <= run_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/relay_pulse_motor_sequencer.sv =====
// Top level of the relay pulse motor sequencer.
// Usage: each input transaction is either a 1 ms tick or a command (start, start
// without stop, stop, stop both, raw start pulse, raw stop pulse). Every input
// transaction produces exactly one result transaction with the two relay drive
// levels, the motor mode, the busy and rejected flags and the run time.
// Configuration: cfg_we writes cfg_data into the register picked by cfg_index
// (0 start pulse, 1 stop pulse, 2 switch gap) in the same cycle; write only
// while no transaction is in flight.
// Path: an accepted item is written into the queue, then popped into the result
// register, which presents it on out_tdata.
// Throughput: one item per cycle while out_tready is high; the back-end sequencer
// state updates once per item, including chains of zero-length phases.
// A two-entry queue separates the decoder from the sequencer, and the result
// register lets a new item be processed while the previous result is taken.
// When out_tready is low the result holds, the queue fills and in_tready drops.
// Reset (rst_n low, synchronous): motor idle, no sequence, run time zero, queue
// empty, registers back to 1000, 1000 and 500 ticks.
`default_nettype none
module relay_pulse_motor_sequencer import rpms_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int RUN_BITS   = RUN_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_W-1:0]      in_tdata,   // action[2:0], direction[3], with_pulse[4]
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // relay_extend_on[0], relay_retract_on[1], motor_mode[3:2], busy_res[4],
  // rejected[5], run_time_ms[37:6]
  output logic [OUT_W-1:0]          out_tdata
);

  logic  q_full, q_push, q_valid, q_pop;
  item_t push_item, head_item;

  rpms_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  rpms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  rpms_back #(
    .COUNT_BITS (COUNT_BITS),
    .RUN_BITS   (RUN_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== sv/rpms_checker.sv =====
// Port-level checker for the relay pulse motor sequencer, bound to the top level.
`default_nettype none
`include "relay_pulse_motor_sequencer_defines.svh"
module rpms_checker import rpms_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_tvalid,
  input wire logic                 out_tready,
  input wire logic [OUT_W-1:0]     out_tdata
);

  logic stalled;

  assign stalled = out_tvalid && !out_tready;

  `RPMS_ASSERT_NEXT(a_hold_valid, clk, rst_n, stalled, out_tvalid, "result dropped while stalled")
  `RPMS_ASSERT_NEXT(a_hold_data, clk, rst_n, stalled, $stable(out_tdata), "result changed while stalled")

  // Only one relay is ever driven, and only while a sequence is running.
  `RPMS_ASSERT_NOW(a_one_relay, clk, rst_n, out_tvalid, !(out_tdata[0] && out_tdata[1]), "both relays driven")
  `RPMS_ASSERT_NOW(a_relay_busy, clk, rst_n, out_tvalid && (out_tdata[0] || out_tdata[1]), out_tdata[4], "relay driven without a sequence")

endmodule

bind relay_pulse_motor_sequencer rpms_checker u_rpms_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the relay pulse motor sequencer.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import rpms_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic                 ext;
    logic                 ret;
    mode_t                mode;
    logic                 busy;
    logic                 rej;
    logic [RUN_OUT_W-1:0] run;
  } relay_result_t;

  // Tracks the sequencer state and holds the relay results still to come.
  class motor_scoreboard;
    logic [CFG_W-1:0]     start_len = START_PULSE_RST;
    logic [CFG_W-1:0]     stop_len  = STOP_PULSE_RST;
    logic [CFG_W-1:0]     gap_len   = SWITCH_GAP_RST;
    mode_t                mode       = MODE_IDLE;
    mode_t                final_mode = MODE_IDLE;
    phase_t               phase      = PH_NONE;
    logic [CFG_W-1:0]     countdown  = '0;
    logic                 tgt_dir    = 1'b0;
    logic [RUN_OUT_W-1:0] run_cnt    = '0;
    relay_result_t        relay_q[$];
    int                   errors = 0;
    int                   checked = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_START_PULSE: start_len = val;
        REG_STOP_PULSE:  stop_len = val;
        REG_SWITCH_GAP:  gap_len = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return relay_q.size();
    endfunction

    function bit busy();
      return phase != PH_NONE;
    endfunction

    function void enter(phase_t p, logic [CFG_W-1:0] len);
      phase = p;
      countdown = len;
    endfunction

    // Ends the current phase and moves on to the next one of its sequence.
    function void advance();
      case (phase)
        PH_STOP_RUN: begin
          mode = MODE_IDLE;
          enter(PH_GAP, gap_len);
        end
        PH_GAP:      enter(PH_START, start_len);
        PH_START: begin
          mode = final_mode;
          run_cnt = '0;
          enter(PH_NONE, '0);
        end
        PH_STOP: begin
          mode = final_mode;
          enter(PH_NONE, '0);
        end
        PH_EXT_STOP: enter(PH_BOTH_GAP, CFG_W'(BOTH_GAP_TICKS));
        PH_BOTH_GAP: enter(PH_RET_STOP, stop_len);
        PH_RET_STOP: begin
          mode = MODE_IDLE;
          enter(PH_NONE, '0);
        end
        default:     enter(PH_NONE, '0);
      endcase
    endfunction

    function void note_input(kind_t act, logic dir, logic pulse);
      relay_result_t r;
      r.rej = 1'b0;
      r.ext = 1'b0;
      r.ret = 1'b0;
      if (act == K_TICK) begin
        if (mode != MODE_IDLE && run_cnt != RUN_OUT_MAX) run_cnt++;
        if (phase != PH_NONE && countdown != 0) countdown--;
      end else if (act == K_INVALID || phase != PH_NONE) begin
        r.rej = 1'b1;
      end else begin
        tgt_dir = dir;
        case (act)
          K_START: begin
            final_mode = dir ? MODE_RET : MODE_EXT;
            if (mode != MODE_IDLE) enter(PH_STOP_RUN, stop_len);
            else enter(PH_START, start_len);
          end
          K_START_NS, K_RAW_START: begin
            final_mode = dir ? MODE_RET : MODE_EXT;
            enter(PH_START, start_len);
          end
          K_STOP: begin
            final_mode = MODE_IDLE;
            if (pulse) enter(PH_STOP, stop_len);
            else mode = MODE_IDLE;
          end
          K_STOP_BOTH: enter(PH_EXT_STOP, stop_len);
          default: begin
            // Raw stop pulse leaves the motor mode as it is.
            final_mode = mode;
            enter(PH_STOP, stop_len);
          end
        endcase
      end
      // Phases of zero length end within the same transaction.
      while (phase != PH_NONE && countdown == 0) advance();
      case (phase)
        PH_STOP_RUN: if (mode == MODE_RET) r.ret = 1'b1; else r.ext = 1'b1;
        PH_START, PH_STOP: if (tgt_dir) r.ret = 1'b1; else r.ext = 1'b1;
        PH_EXT_STOP: r.ext = 1'b1;
        PH_RET_STOP: r.ret = 1'b1;
        default: ;
      endcase
      r.mode = mode;
      r.busy = phase != PH_NONE;
      r.run = (mode == MODE_IDLE) ? '0 : run_cnt;
      relay_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      relay_result_t e;
      if (relay_q.size() == 0) begin
        $error("unexpected result transaction, data %h", d);
        errors++;
        return;
      end
      e = relay_q.pop_front();
      checked++;
      if (d[0] !== e.ext) begin
        $error("relay_extend_on expected %0d actual %0d", e.ext, d[0]);
        errors++;
      end
      if (d[1] !== e.ret) begin
        $error("relay_retract_on expected %0d actual %0d", e.ret, d[1]);
        errors++;
      end
      if (d[3:2] !== e.mode) begin
        $error("motor_mode expected %0d actual %0d", e.mode, d[3:2]);
        errors++;
      end
      if (d[4] !== e.busy) begin
        $error("busy_res expected %0d actual %0d", e.busy, d[4]);
        errors++;
      end
      if (d[5] !== e.rej) begin
        $error("rejected expected %0d actual %0d", e.rej, d[5]);
        errors++;
      end
      if (d[37:6] !== e.run) begin
        $error("run_time_ms expected %0d actual %0d", e.run, d[37:6]);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata;   // action[2:0], direction[3], with_pulse[4]
  logic                 out_tvalid;
  logic                 out_tready;
  // relay_extend_on[0], relay_retract_on[1], motor_mode[3:2], busy_res[4],
  // rejected[5], run_time_ms[37:6]
  logic [OUT_W-1:0]     out_tdata;

  motor_scoreboard sb = new();
  int burst_left = 0;

  relay_pulse_motor_sequencer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Receiver: cycles through several stall styles, with one long hold-off
  // once traffic is flowing so that the input side has to back up.
  initial begin
    int cyc;
    bit held;
    cyc = 0;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!held && sb.checked >= 200) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end else begin
        case ((cyc / 97) % 4)
          0: out_tready <= 1'b1;
          1: out_tready <= (cyc % 3) != 0;
          2: out_tready <= $urandom_range(0, 1);
          default: out_tready <= $urandom_range(0, 9) < 8;
        endcase
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  // Offers one item in bursts with random gaps and records it once accepted.
  task automatic send_item(kind_t act, logic dir, logic pulse);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, pulse, dir, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(act, dir, pulse);
  endtask

  task automatic tick_until_idle();
    while (sb.busy()) send_item(K_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [CFG_W-1:0] start_v, logic [CFG_W-1:0] stop_v,
                           logic [CFG_W-1:0] gap_v);
    quiesce();
    write_reg(REG_START_PULSE, start_v);
    write_reg(REG_STOP_PULSE, stop_v);
    write_reg(REG_SWITCH_GAP, gap_v);
  endtask

  // Commands are more likely when no sequence runs, so most of them start one.
  task automatic random_traffic(int n);
    for (int i = 0; i < n; i++) begin
      kind_t k;
      bit tick;
      tick = sb.busy() ? ($urandom_range(0, 99) < 88) : ($urandom_range(0, 99) < 45);
      if (tick) k = K_TICK;
      else if ($urandom_range(0, 19) == 0) k = K_INVALID;
      else k = kind_t'($urandom_range(1, 6));
      send_item(k, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset lengths: invalid action, stop while idle, busy rejection.
    send_item(K_TICK, 1'b0, 1'b0);
    send_item(K_INVALID, 1'b1, 1'b1);
    send_item(K_STOP, 1'b0, 1'b0);
    send_item(K_START, 1'b0, 1'b0);
    send_item(K_START_NS, 1'b1, 1'b0);
    send_item(K_STOP_BOTH, 1'b0, 1'b1);
    send_item(K_INVALID, 1'b0, 1'b0);
    tick_until_idle();

    // Short lengths with no switch gap.
    configure(16'd3, 16'd2, 16'd0);
    send_item(K_START, 1'b1, 1'b0);
    tick_until_idle();
    send_item(K_START, 1'b1, 1'b1);   // same direction still stops and restarts
    tick_until_idle();
    send_item(K_START, 1'b0, 1'b0);   // direction change
    tick_until_idle();
    repeat (3) send_item(K_TICK, 1'b1, 1'b1);
    send_item(K_STOP, 1'b0, 1'b1);
    tick_until_idle();
    send_item(K_START_NS, 1'b1, 1'b0);
    tick_until_idle();
    send_item(K_RAW_STOP, 1'b0, 1'b0);
    tick_until_idle();
    send_item(K_STOP_BOTH, 1'b1, 1'b0);
    tick_until_idle();
    send_item(K_RAW_START, 1'b0, 1'b1);
    tick_until_idle();
    send_item(K_STOP, 1'b1, 1'b0);    // moving, no pulse

    // All lengths zero: every sequence but stop both completes inside its command.
    configure(16'd0, 16'd0, 16'd0);
    send_item(K_START, 1'b1, 1'b0);
    send_item(K_START, 1'b0, 1'b1);
    send_item(K_STOP_BOTH, 1'b0, 1'b0);
    send_item(K_RAW_STOP, 1'b1, 1'b0);
    send_item(K_STOP, 1'b0, 1'b1);
    send_item(K_RAW_START, 1'b1, 1'b0);
    send_item(K_TICK, 1'b0, 1'b0);

    configure(16'd5, 16'd3, 16'd1);
    random_traffic(100);
    configure(16'd1, 16'd1, 16'd0);
    random_traffic(100);
    configure(16'd12, 16'd7, 16'd20);
    random_traffic(100);
    configure(16'd0, 16'd4, 16'd3);
    random_traffic(100);
    for (int ph = 0; ph < 2; ph++) begin
      configure(CFG_W'($urandom_range(0, 30)), CFG_W'($urandom_range(0, 30)),
                CFG_W'($urandom_range(0, 60)));
      random_traffic(100);
    end

    // Longest lengths: a direction change enters a full-range switch gap, which
    // is left running when the run ends.
    tick_until_idle();
    send_item(K_START_NS, 1'b0, 1'b0);
    tick_until_idle();
    configure(16'hFFFF, 16'd2, 16'hFFFF);
    send_item(K_START, 1'b1, 1'b1);
    repeat (20) send_item(K_TICK, 1'b0, 1'b0);
    send_item(K_STOP, 1'b0, 1'b0);    // rejected, the gap is still counting

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
